>>> design/bfct_pkg.sv
// ----------------------------------------------------------------------------
// bfct_pkg
// Shared types, constants and helpers for the BSSID frame counter table.
// ----------------------------------------------------------------------------
package bfct_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int COUNT_W       = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W        = 48;
  localparam int BYTE_W        = 8;
  localparam int PORT_IDX_W    = 7;
  localparam int PORT_COUNT_W  = 32;

  // frame control byte decode
  localparam logic [BYTE_W-1:0] FC_BEACON    = 8'h80;
  localparam logic [BYTE_W-1:0] FC_TYPE_MASK = 8'h0C;
  localparam logic [BYTE_W-1:0] FC_TYPE_DATA = 8'h08;

  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_READ    = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    OUT_IGNORED    = 3'd0,
    OUT_BEACON_HIT = 3'd1,
    OUT_INSERTED   = 3'd2,
    OUT_FULL       = 3'd3,
    OUT_DATA_HIT   = 3'd4,
    OUT_DATA_MISS  = 3'd5,
    OUT_READ       = 3'd6
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] beacon;
    logic [COUNT_W-1:0] data;
    logic [BYTE_W-1:0]  signal;
    logic [BYTE_W-1:0]  nlen;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  typedef struct packed {
    outcome_t                outcome;
    logic [PORT_IDX_W-1:0]   index;
    logic                    valid;
    logic [ADDR_W-1:0]       addr;
    logic [PORT_COUNT_W-1:0] beacon;
    logic [PORT_COUNT_W-1:0] data;
    logic [BYTE_W-1:0]       signal;
    logic [BYTE_W-1:0]       nlen;
  } result_t;

  // saturating increment
  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic result_t report(input outcome_t code, input logic [IDX_W-1:0] idx,
                                     input entry_t e);
    result_t r;
    r.outcome = code;
    r.index   = PORT_IDX_W'(idx);
    r.valid   = 1'b1;
    r.addr    = e.addr;
    r.beacon  = PORT_COUNT_W'(e.beacon);
    r.data    = PORT_COUNT_W'(e.data);
    r.signal  = e.signal;
    r.nlen    = e.nlen;
    return r;
  endfunction

  function automatic result_t report_none(input outcome_t code,
                                          input logic [PORT_IDX_W-1:0] idx);
    result_t r;
    r         = '0;
    r.outcome = code;
    r.index   = idx;
    return r;
  endfunction

endpackage

>>> design/bfct_table.sv
// ----------------------------------------------------------------------------
// bfct_table
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfct_table (
  input  logic              clk,
  input  bfct_pkg::mem_req_t req,
  output bfct_pkg::entry_t   rd_data
);

  bfct_pkg::entry_t mem [bfct_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> design/bssid_frame_counter_table_unit.sv
// ----------------------------------------------------------------------------
// bssid_frame_counter_table_unit
// Access point table keyed by BSSID with saturating beacon and data counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transfer:
//   opcode 0 observes a frame (beacon: look up / append; data: look up),
//   opcode 1 reads the entry at read_index. Every request yields exactly one
//   result transfer on the output channel (out_valid/out_ready).
//   Lookups walk the filled entries one per cycle through a single 48-bit
//   comparator fed by the table's registered read port; a lookup ends on a
//   hit or once every filled entry has been compared. in_ready is high only
//   while the sequencer is idle, so one request is in flight at a time.
//   The output register is separate from the sequencer: a new request is taken
//   while the last result still waits; a finished result is held in a staging
//   register until the output register frees up.
//   Reset clears the fill count and the handshake state only; table contents
//   are never read before they are written.
// ----------------------------------------------------------------------------
module bssid_frame_counter_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  frame_control,
  input  logic [47:0] beacon_address,
  input  logic [47:0] data_address,
  input  logic [7:0]  signal_raw,
  input  logic [7:0]  name_length,
  input  logic [6:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  outcome,
  output logic [6:0]  entry_index,
  output logic        entry_valid,
  output logic [47:0] entry_address,
  output logic [31:0] beacon_total,
  output logic [31:0] data_total,
  output logic [7:0]  entry_signal,
  output logic [7:0]  entry_name_length
);

  localparam int IDX_W  = bfct_pkg::IDX_W;
  localparam int FILL_W = bfct_pkg::FILL_W;

  bfct_pkg::state_t  state, state_next;
  bfct_pkg::mem_req_t req;
  bfct_pkg::entry_t   rd_data;
  bfct_pkg::entry_t   upd;
  bfct_pkg::result_t  res, res_next;
  bfct_pkg::result_t  out_reg;

  logic [FILL_W-1:0]          fill_count, fill_count_next;
  logic [FILL_W-1:0]          scan_idx, scan_idx_next;
  logic                       pend, pend_next;
  logic [IDX_W-1:0]           pend_idx, pend_idx_next;
  logic [bfct_pkg::ADDR_W-1:0] key, key_next;
  logic                       is_beacon, is_beacon_next;
  logic [7:0]                 sig, sig_next;
  logic [7:0]                 nlen, nlen_next;

  logic accept;
  logic in_read, in_beacon, in_data, in_range;
  logic match, scan_done, has_room;

  bfct_table u_table (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // request decode
  assign accept    = in_valid && in_ready;
  assign in_read   = (opcode == bfct_pkg::OP_READ);
  assign in_beacon = (frame_control == bfct_pkg::FC_BEACON);
  assign in_data   = ((frame_control & bfct_pkg::FC_TYPE_MASK) == bfct_pkg::FC_TYPE_DATA);
  assign in_range  = (int'(read_index) < int'(fill_count));

  // shared comparator: registered read data against the latched key
  assign match     = pend && (rd_data.addr == key);
  assign scan_done = !pend && (scan_idx >= fill_count);
  assign has_room  = (fill_count < FILL_W'(bfct_pkg::TABLE_ENTRIES));

  // entry after the count bump for a hit
  always_comb begin
    upd = rd_data;
    if (is_beacon) begin
      upd.beacon = bfct_pkg::bump(rd_data.beacon);
    end else begin
      upd.data = bfct_pkg::bump(rd_data.data);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bfct_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_read) begin
            state_next = in_range ? bfct_pkg::ST_READ : bfct_pkg::ST_LOAD;
          end else if (in_beacon || in_data) begin
            state_next = bfct_pkg::ST_SEARCH;
          end else begin
            state_next = bfct_pkg::ST_LOAD;
          end
        end
      end
      bfct_pkg::ST_SEARCH: begin
        if (match || scan_done) begin
          state_next = bfct_pkg::ST_LOAD;
        end
      end
      bfct_pkg::ST_READ: begin
        state_next = bfct_pkg::ST_LOAD;
      end
      bfct_pkg::ST_LOAD: begin
        if (!out_valid || out_ready) begin
          state_next = bfct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfct_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and table control
  always_comb begin
    req             = '0;
    req.rd_addr     = scan_idx[IDX_W-1:0];
    req.wr_data     = upd;
    res_next        = res;
    fill_count_next = fill_count;
    scan_idx_next   = scan_idx;
    pend_next       = 1'b0;
    pend_idx_next   = pend_idx;
    key_next        = key;
    is_beacon_next  = is_beacon;
    sig_next        = sig;
    nlen_next       = nlen;
    case (state)
      bfct_pkg::ST_IDLE: begin
        if (accept) begin
          key_next       = in_beacon ? beacon_address : data_address;
          is_beacon_next = in_beacon;
          sig_next       = signal_raw;
          nlen_next      = name_length;
          scan_idx_next  = '0;
          if (in_read) begin
            if (in_range) begin
              req.rd_en     = 1'b1;
              req.rd_addr   = IDX_W'(read_index);
              pend_idx_next = IDX_W'(read_index);
            end else begin
              res_next = bfct_pkg::report_none(bfct_pkg::OUT_READ, read_index);
            end
          end else if (!(in_beacon || in_data)) begin
            res_next = bfct_pkg::report_none(bfct_pkg::OUT_IGNORED, '0);
          end
        end
      end
      bfct_pkg::ST_SEARCH: begin
        if (match) begin
          req.wr_en   = 1'b1;
          req.wr_addr = pend_idx;
          res_next    = bfct_pkg::report(is_beacon ? bfct_pkg::OUT_BEACON_HIT
                                                   : bfct_pkg::OUT_DATA_HIT, pend_idx, upd);
        end else if (scan_done) begin
          if (!is_beacon) begin
            res_next = bfct_pkg::report_none(bfct_pkg::OUT_DATA_MISS, '0);
          end else if (has_room) begin
            req.wr_en          = 1'b1;
            req.wr_addr        = fill_count[IDX_W-1:0];
            req.wr_data.addr   = key;
            req.wr_data.beacon = '0;
            req.wr_data.data   = '0;
            req.wr_data.signal = sig;
            req.wr_data.nlen   = nlen;
            fill_count_next    = fill_count + 1'b1;
            res_next = bfct_pkg::report(bfct_pkg::OUT_INSERTED, fill_count[IDX_W-1:0],
                                        req.wr_data);
          end else begin
            res_next = bfct_pkg::report_none(bfct_pkg::OUT_FULL, '0);
          end
        end else if (scan_idx < fill_count) begin
          // issue the next entry; it is compared in the following cycle
          req.rd_en     = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan_idx[IDX_W-1:0];
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      bfct_pkg::ST_READ: begin
        res_next = bfct_pkg::report(bfct_pkg::OUT_READ, pend_idx, rd_data);
      end
      bfct_pkg::ST_LOAD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bfct_pkg::ST_IDLE;
      fill_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      pend       <= pend_next;
      if (state == bfct_pkg::ST_LOAD && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res       <= res_next;
    scan_idx  <= scan_idx_next;
    pend_idx  <= pend_idx_next;
    key       <= key_next;
    is_beacon <= is_beacon_next;
    sig       <= sig_next;
    nlen      <= nlen_next;
    if (state == bfct_pkg::ST_LOAD && (!out_valid || out_ready)) begin
      out_reg <= res;
    end
  end

  assign in_ready          = (state == bfct_pkg::ST_IDLE);
  assign outcome           = out_reg.outcome;
  assign entry_index       = out_reg.index;
  assign entry_valid       = out_reg.valid;
  assign entry_address     = out_reg.addr;
  assign beacon_total      = out_reg.beacon;
  assign data_total        = out_reg.data;
  assign entry_signal      = out_reg.signal;
  assign entry_name_length = out_reg.nlen;

  // ---------------------------------------------------------------- checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(bfct_pkg::TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill_count != $past(fill_count)) |->
      (fill_count == $past(fill_count) + 1'b1 && $past(state) == bfct_pkg::ST_SEARCH))
    else $error("fill count moved other than by one insert");

  a_scan_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == bfct_pkg::ST_SEARCH && pend) |-> ({1'b0, pend_idx} < fill_count))
    else $error("lookup compared an unfilled entry");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == bfct_pkg::OUT_BEACON_HIT || outcome == bfct_pkg::OUT_DATA_HIT
                   || outcome == bfct_pkg::OUT_INSERTED)) |-> entry_valid)
    else $error("hit or insert reported without a valid entry");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the BSSID frame counter table: random and directed
// frames, reads and stalls on both channels, checked against a local table.
// ----------------------------------------------------------------------------
module tb;

  // Long receiver hold-off, in cycles; long enough to back up the whole pipe.
  localparam int HOLD_OFF_CYCLES = 400;
  // Quiet-cycle limit: hold-off + worst search + longest gap, times ~5.
  localparam int STALL_LIMIT     = 3000;
  // Settle time after the last result; covers the slowest search.
  localparam int DRAIN_CYCLES    = 150;
  localparam int MAX_REPORTS     = 10;
  localparam int ENTRIES         = bfct_pkg::TABLE_ENTRIES;

  // One request on the input channel.
  typedef struct {
    bfct_pkg::opcode_t op;
    logic [7:0]  fc;
    logic [47:0] bssid;
    logic [47:0] daddr;
    logic [7:0]  sig;
    logic [7:0]  nlen;
    logic [6:0]  ridx;
  } frame_req_t;

  logic        clk;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        opcode         = 1'b0;
  logic [7:0]  frame_control  = '0;
  logic [47:0] beacon_address = '0;
  logic [47:0] data_address   = '0;
  logic [7:0]  signal_raw     = '0;
  logic [7:0]  name_length    = '0;
  logic [6:0]  read_index     = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [2:0]  outcome;
  logic [6:0]  entry_index;
  logic        entry_valid;
  logic [47:0] entry_address;
  logic [31:0] beacon_total;
  logic [31:0] data_total;
  logic [7:0]  entry_signal;
  logic [7:0]  entry_name_length;

  // Local copy of the access point table, updated as each request transfers.
  logic [47:0]                  ap_addr    [ENTRIES];
  logic [bfct_pkg::COUNT_W-1:0] ap_beacons [ENTRIES];
  logic [bfct_pkg::COUNT_W-1:0] ap_datas   [ENTRIES];
  logic [7:0]                   ap_sig     [ENTRIES];
  logic [7:0]                   ap_nlen    [ENTRIES];
  int                           ap_fill = 0;

  // Replies owed by the block, oldest first.
  bfct_pkg::result_t table_replies_due [$];
  int                mismatches = 0;

  // Both sides run back to back while set.
  bit idle_off     = 1'b0;
  // Asks the receiver for one long hold-off; cleared by the receiver.
  bit hold_off_req = 1'b0;

  bssid_frame_counter_table_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Table prediction
  // --------------------------------------------------------------------------

  function automatic bfct_pkg::result_t entry_reply(input bfct_pkg::outcome_t code,
                                                    input int idx);
    bfct_pkg::result_t r;
    r.outcome = code;
    r.index   = 7'(idx);
    r.valid   = 1'b1;
    r.addr    = ap_addr[idx];
    r.beacon  = ap_beacons[idx];
    r.data    = ap_datas[idx];
    r.signal  = ap_sig[idx];
    r.nlen    = ap_nlen[idx];
    return r;
  endfunction

  // Only filled slots are searched, so empty ones never match.
  function automatic int find_ap(input logic [47:0] addr);
    for (int i = 0; i < ap_fill; i++)
      if (ap_addr[i] == addr) return i;
    return -1;
  endfunction

  function automatic bfct_pkg::result_t predict_table_reply(input frame_req_t req);
    bfct_pkg::result_t r;
    int                hit;
    r = '0;
    if (req.op == bfct_pkg::OP_READ) begin
      // past the fill: index echoed, everything else zero
      r.outcome = bfct_pkg::OUT_READ;
      r.index   = req.ridx;
      if (req.ridx < ap_fill) r = entry_reply(bfct_pkg::OUT_READ, req.ridx);
    end else if (req.fc == bfct_pkg::FC_BEACON) begin
      hit = find_ap(req.bssid);
      if (hit >= 0) begin
        if (ap_beacons[hit] != '1) ap_beacons[hit]++;
        r = entry_reply(bfct_pkg::OUT_BEACON_HIT, hit);
      end else if (ap_fill < ENTRIES) begin
        // new network; a zero name length (hidden name) is kept as is
        ap_addr[ap_fill]    = req.bssid;
        ap_beacons[ap_fill] = '0;
        ap_datas[ap_fill]   = '0;
        ap_sig[ap_fill]     = req.sig;
        ap_nlen[ap_fill]    = req.nlen;
        r = entry_reply(bfct_pkg::OUT_INSERTED, ap_fill);
        ap_fill++;
      end else begin
        r.outcome = bfct_pkg::OUT_FULL;
      end
    end else if ((req.fc & bfct_pkg::FC_TYPE_MASK) == bfct_pkg::FC_TYPE_DATA) begin
      hit = find_ap(req.daddr);
      if (hit >= 0) begin
        if (ap_datas[hit] != '1) ap_datas[hit]++;
        r = entry_reply(bfct_pkg::OUT_DATA_HIT, hit);
      end else begin
        r.outcome = bfct_pkg::OUT_DATA_MISS;
      end
    end else begin
      r.outcome = bfct_pkg::OUT_IGNORED;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, a few long ones; none while idle_off is set.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (idle_off || roll < 50) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [47:0] rand_bssid();
    return {16'($urandom), $urandom};
  endfunction

  // Address already in the table; caller makes sure the table is not empty.
  function automatic logic [47:0] known_bssid();
    return ap_addr[$urandom_range(ap_fill - 1)];
  endfunction

  // Every field random, so unused fields toggle too.
  function automatic frame_req_t rand_req();
    frame_req_t req;
    req.op    = bfct_pkg::opcode_t'($urandom_range(1));
    req.fc    = 8'($urandom);
    req.bssid = rand_bssid();
    req.daddr = rand_bssid();
    req.sig   = 8'($urandom);
    req.nlen  = 8'($urandom);
    req.ridx  = 7'($urandom);
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Drives one request and holds it until the transfer; valid stays up into
  // the next request when no gap follows.
  task automatic send_frame(input frame_req_t req);
    int gap;
    in_valid       <= 1'b1;
    opcode         <= req.op;
    frame_control  <= req.fc;
    beacon_address <= req.bssid;
    data_address   <= req.daddr;
    signal_raw     <= req.sig;
    name_length    <= req.nlen;
    read_index     <= req.ridx;
    do @(posedge clk); while (!in_ready);
    table_replies_due.push_back(predict_table_reply(req));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_beacon(input logic [47:0] bssid, input logic [7:0] sig,
                             input logic [7:0] nlen);
    frame_req_t req;
    req       = rand_req();
    req.op    = bfct_pkg::OP_OBSERVE;
    req.fc    = bfct_pkg::FC_BEACON;
    req.bssid = bssid;
    req.sig   = sig;
    req.nlen  = nlen;
    send_frame(req);
  endtask

  task automatic send_data(input logic [7:0] fc, input logic [47:0] daddr);
    frame_req_t req;
    req       = rand_req();
    req.op    = bfct_pkg::OP_OBSERVE;
    req.fc    = fc;
    req.daddr = daddr;
    send_frame(req);
  endtask

  task automatic send_read(input logic [6:0] idx);
    frame_req_t req;
    req      = rand_req();
    req.op   = bfct_pkg::OP_READ;
    req.ridx = idx;
    send_frame(req);
  endtask

  task automatic send_other(input logic [7:0] fc);
    frame_req_t req;
    req    = rand_req();
    req.op = bfct_pkg::OP_OBSERVE;
    req.fc = fc;
    send_frame(req);
  endtask

  // Beacons, data frames, reads and noise; addresses lean toward known
  // entries so hits and deep searches are common.
  task automatic run_mixed_traffic(input int count);
    frame_req_t req;
    int         pick;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 59) idle_off = ($urandom_range(3) == 0);
      req  = rand_req();
      pick = $urandom_range(99);
      if (pick < 35) begin
        req.op = bfct_pkg::OP_OBSERVE;
        req.fc = bfct_pkg::FC_BEACON;
        if (ap_fill > 0 && $urandom_range(99) < 60) req.bssid = known_bssid();
      end else if (pick < 65) begin
        req.op = bfct_pkg::OP_OBSERVE;
        req.fc = (req.fc & ~bfct_pkg::FC_TYPE_MASK) | bfct_pkg::FC_TYPE_DATA;
        if (ap_fill > 0 && $urandom_range(99) < 70) req.daddr = known_bssid();
      end else if (pick < 85) begin
        req.op = bfct_pkg::OP_READ;
        if (ap_fill > 0 && $urandom_range(99) < 80)
          req.ridx = 7'($urandom_range(ap_fill - 1));
      end else begin
        // random control byte: mostly frames the table ignores
        req.op = bfct_pkg::OP_OBSERVE;
      end
      send_frame(req);
    end
    idle_off = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_directed_cases();
    frame_req_t req;
    send_other(8'h00);                      // management, not a beacon
    send_other(8'hFF);                      // reserved type bits
    send_other(8'h84);                      // control frame
    send_other(8'h81);                      // one bit off the beacon code
    send_read(7'd0);                        // empty table
    send_data(bfct_pkg::FC_TYPE_DATA, 48'h0); // empty slots must not match zero
    send_beacon(48'h0, 8'h00, 8'h00);       // insert, hidden name
    send_beacon('1, 8'hFF, 8'hFF);          // insert, all ones
    send_beacon(48'h0, 8'hAA, 8'h55);       // hit: stored bytes unchanged
    send_beacon('1, 8'h00, 8'h00);          // hit
    send_data(8'h08, 48'h0);                // data hit
    send_data(8'hFB, '1);                   // data type, all other bits set
    send_data(8'h88, 48'h1);                // data miss
    // data frame carrying a known BSSID in the beacon slot: still a miss
    req       = rand_req();
    req.op    = bfct_pkg::OP_OBSERVE;
    req.fc    = bfct_pkg::FC_TYPE_DATA;
    req.bssid = '1;
    req.daddr = 48'h8000_0000_0000;
    send_frame(req);
    // read opcode wins over a beacon control byte
    req      = rand_req();
    req.op   = bfct_pkg::OP_READ;
    req.fc   = bfct_pkg::FC_BEACON;
    req.ridx = 7'd1;
    send_frame(req);
    send_read(7'd0);
    send_read(7'd2);                        // just past the fill
    send_read(7'h7F);
  endtask

  task automatic test_random_traffic();
    run_mixed_traffic(500);
  endtask

  // Receiver stops for a long stretch while reads keep coming, so the result
  // stages fill and the input channel has to stall.
  task automatic test_back_pressure();
    idle_off     = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < 16; i++) send_read(7'($urandom));
    idle_off = 1'b0;
  endtask

  task automatic test_table_full();
    frame_req_t req;
    while (ap_fill < ENTRIES) begin
      req    = rand_req();
      req.op = bfct_pkg::OP_OBSERVE;
      req.fc = bfct_pkg::FC_BEACON;
      send_frame(req);
    end
    send_beacon(rand_bssid(), 8'($urandom), 8'($urandom));  // no room left
    send_beacon(ap_addr[ENTRIES-1], 8'h00, 8'h00);          // last slot hit
    send_data(bfct_pkg::FC_TYPE_DATA, ap_addr[ENTRIES-1]);
    send_data(bfct_pkg::FC_TYPE_DATA, rand_bssid());        // full-length miss
    run_mixed_traffic(150);
    idle_off = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (i == ENTRIES / 2) idle_off = 1'b0;
      send_read(7'(i));
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Receiver: random gaps after each transfer, one long hold-off on request.
  initial begin : result_sink
    int gap;
    int hold;
    gap  = 0;
    hold = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold         = HOLD_OFF_CYCLES - 1;
        out_ready    <= 1'b0;
      end else begin
        if (out_valid && out_ready) gap = pick_gap();
        if (gap > 0) begin
          gap--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic check_reply();
    bfct_pkg::result_t exp;
    if (table_replies_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: result with nothing pending: outcome=%0d index=%0d",
                 $time, outcome, entry_index);
    end else begin
      exp = table_replies_due.pop_front();
      if (outcome !== exp.outcome || entry_index !== exp.index ||
          entry_valid !== exp.valid || entry_address !== exp.addr ||
          beacon_total !== exp.beacon || data_total !== exp.data ||
          entry_signal !== exp.signal || entry_name_length !== exp.nlen) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result mismatch", $time);
          $display("  exp outcome=%0d idx=%0d vld=%0b addr=%h bcn=%0d dat=%0d sig=%h nlen=%0d",
                   exp.outcome, exp.index, exp.valid, exp.addr, exp.beacon,
                   exp.data, exp.signal, exp.nlen);
          $display("  got outcome=%0d idx=%0d vld=%0b addr=%h bcn=%0d dat=%0d sig=%h nlen=%0d",
                   outcome, entry_index, entry_valid, entry_address,
                   beacon_total, data_total, entry_signal, entry_name_length);
        end
      end
    end
  endtask

  always @(posedge clk)
    if (!rst && out_valid && out_ready) check_reply();

  // Ends the run when neither channel has moved a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic();
    test_back_pressure();
    test_table_full();
    in_valid <= 1'b0;
    while (table_replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && table_replies_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
design/bfct_pkg.sv
design/bfct_table.sv
design/bssid_frame_counter_table_unit.sv
verif/tb.sv
